// ===== hdl/tlsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsa_pkg
// Types and constants shared by the slot allocator modules.
// ----------------------------------------------------------------------------
package tlsa_pkg;

  localparam int unsigned PAGE_W  = 6;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ADDR_W  = 22;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // register indexes (byte address 4*index)
  localparam logic [2:0] REG_SLOTS_PER_PAGE = 3'd0;
  localparam logic [2:0] REG_SLOT_BYTES     = 3'd1;
  localparam logic [2:0] REG_PAGE_BYTES     = 3'd2;
  localparam logic [2:0] REG_HEADER_BYTES   = 3'd3;
  localparam logic [2:0] REG_PAGES_IN_USE   = 3'd4;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOROOM  = 2'd1;
  localparam logic [1:0] ST_NOTUSED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_OUT,
    S_SWEEP,
    S_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic [6:0]  slots_per_page;
    logic [12:0] slot_bytes;
    logic [16:0] page_bytes;
    logic [12:0] header_bytes;
    logic [6:0]  pages_in_use;
  } cfg_t;

  typedef struct packed {
    logic              accept;
    logic              rd_item;
    logic              modify;
    logic              finish;
    logic              sweep_rd;
    logic [PAGE_W-1:0] sweep_addr;
  } dp_cmd_t;

endpackage

// ===== hdl/tlsa_regs.sv =====
// ----------------------------------------------------------------------------
// tlsa_regs
// APB-style configuration registers; flags a rewrite of slots per page.
// ----------------------------------------------------------------------------
module tlsa_regs
  import tlsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o,
  output logic               sweep_req_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d       = cfg_q;
    sweep_req_o = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SLOTS_PER_PAGE: begin
          cfg_d.slots_per_page = pwdata[6:0];
          sweep_req_o          = 1'b1;
        end
        REG_SLOT_BYTES:   cfg_d.slot_bytes   = pwdata[12:0];
        REG_PAGE_BYTES:   cfg_d.page_bytes   = pwdata[16:0];
        REG_HEADER_BYTES: cfg_d.header_bytes = pwdata[12:0];
        REG_PAGES_IN_USE: cfg_d.pages_in_use = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SLOTS_PER_PAGE: prdata = {25'd0, cfg_q.slots_per_page};
      REG_SLOT_BYTES:     prdata = {19'd0, cfg_q.slot_bytes};
      REG_PAGE_BYTES:     prdata = {15'd0, cfg_q.page_bytes};
      REG_HEADER_BYTES:   prdata = {19'd0, cfg_q.header_bytes};
      REG_PAGES_IN_USE:   prdata = {25'd0, cfg_q.pages_in_use};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slots_per_page <= 7'd64;
      cfg_q.slot_bytes     <= 13'd16;
      cfg_q.page_bytes     <= 17'd8192;
      cfg_q.header_bytes   <= 13'd12;
      cfg_q.pages_in_use   <= 7'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tlsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlsa_ctrl
// Sequencer: request steps (read, modify, output) and the full-map sweep.
// ----------------------------------------------------------------------------
module tlsa_ctrl
  import tlsa_pkg::*;
#(
  parameter int unsigned NPG = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    sweep_req_i,
  output logic    busy_o,
  output dp_cmd_t cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [PAGE_W-1:0] sweep_q, sweep_d;
  logic              sweep_last;

  assign sweep_last = (sweep_q == PAGE_W'(NPG - 1));

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_READ;
        end else if (sweep_req_i) begin
          state_d = S_SWEEP;
          sweep_d = '0;
        end
      end
      S_READ:  state_d = S_MOD;
      S_MOD:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      S_SWEEP: begin
        if (sweep_req_i) begin
          sweep_d = '0;
        end else if (sweep_last) begin
          state_d = S_DRAIN;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (sweep_req_i) begin
          state_d = S_SWEEP;
          sweep_d = '0;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.accept  = start_i;
      S_READ:  cmd_o.rd_item = 1'b1;
      S_MOD:   cmd_o.modify  = 1'b1;
      S_OUT:   cmd_o.finish  = 1'b1;
      S_SWEEP: begin
        cmd_o.sweep_rd   = 1'b1;
        cmd_o.sweep_addr = sweep_q;
      end
      S_DRAIN: ;
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

endmodule

// ===== hdl/tlsa_dp.sv =====
// ----------------------------------------------------------------------------
// tlsa_dp
// Datapath: full map, slot bitmap and count memories, searches and address.
// ----------------------------------------------------------------------------
module tlsa_dp
  import tlsa_pkg::*;
#(
  parameter int unsigned NPG = 64,
  parameter int unsigned NSL = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  cfg_t              cfg_i,
  input  logic              req_type_i,
  input  logic [PAGE_W-1:0] page_index_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [PAGE_W-1:0] granted_page_o,
  output logic [SLOT_W-1:0] granted_slot_o,
  output logic [ADDR_W-1:0] byte_address_o,
  output logic              page_now_full_o,
  output logic              page_now_empty_o
);

  localparam int unsigned PW = (NPG > 1) ? $clog2(NPG) : 1;
  localparam int unsigned SW = (NSL > 1) ? $clog2(NSL) : 1;

  // storage
  logic [NSL-1:0]   bm_mem  [NPG];
  logic [CNT_W-1:0] cnt_mem [NPG];
  logic [NPG-1:0]   vld_q;
  logic [NPG-1:0]   full_q;

  // effective limits
  logic [6:0] s_eff, np_eff;

  // latched request
  logic              req_q, noroom_q;
  logic [PAGE_W-1:0] page_q;
  logic [SLOT_W-1:0] slot_in_q;

  // read side
  logic             rd_en, vld_rd_q;
  logic [PW-1:0]    rd_idx, page_idx;
  logic [NSL-1:0]   bm_rd_q;
  logic [CNT_W-1:0] cnt_rd_q;
  logic             sw_vld_q;
  logic [PW-1:0]    sw_idx_q;
  logic             page_in_rng, slot_in_rng;

  // page search
  logic              pg_found;
  logic [PAGE_W-1:0] pg_enc;

  // modify step
  logic [NSL-1:0]    bm_cur, avail, bm_new, bit_sel;
  logic [CNT_W-1:0]  cnt_cur, cnt_new;
  logic              sl_found, alloc_ok, free_hit, wr_en, full_new;
  logic [SLOT_W-1:0] sl_enc, sel_slot;
  logic [1:0]        status_d;

  // result
  logic [22:0]       prod_p_q;
  logic [18:0]       prod_s_q;
  logic [1:0]        status_q;
  logic [SLOT_W-1:0] slot_q;
  logic              pnf_q, pne_q;
  logic [23:0]       addr_sum;

  always_comb begin
    if (cfg_i.slots_per_page == 7'd0)          s_eff = 7'd1;
    else if (cfg_i.slots_per_page > 7'(NSL))   s_eff = 7'(NSL);
    else                                       s_eff = cfg_i.slots_per_page;
    if (cfg_i.pages_in_use == 7'd0)            np_eff = 7'd1;
    else if (cfg_i.pages_in_use > 7'(NPG))     np_eff = 7'(NPG);
    else                                       np_eff = cfg_i.pages_in_use;
  end

  // lowest usable page that is not full
  always_comb begin
    pg_found = 1'b0;
    pg_enc   = '0;
    for (int p = NPG - 1; p >= 0; p--) begin
      if ((7'(p) < np_eff) && !full_q[p]) begin
        pg_found = 1'b1;
        pg_enc   = PAGE_W'(p);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q     <= req_type_i;
      slot_in_q <= slot_index_i;
      if (req_type_i == REQ_ALLOC) begin
        page_q   <= pg_found ? pg_enc : '0;
        noroom_q <= !pg_found;
      end else begin
        page_q   <= page_index_i;
        noroom_q <= 1'b0;
      end
    end
  end

  assign page_in_rng = ({1'b0, page_q} < 7'(NPG));
  assign slot_in_rng = ({1'b0, slot_in_q} < 7'(NSL));
  assign page_idx    = page_q[PW-1:0];
  assign rd_idx      = cmd_i.sweep_rd ? cmd_i.sweep_addr[PW-1:0] : page_idx;
  assign rd_en       = cmd_i.sweep_rd | cmd_i.rd_item;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bm_rd_q  <= bm_mem[rd_idx];
      cnt_rd_q <= cnt_mem[rd_idx];
      vld_rd_q <= (cmd_i.sweep_rd | page_in_rng) & vld_q[rd_idx];
      sw_idx_q <= rd_idx;
    end
    if (cmd_i.rd_item) begin
      prod_p_q <= page_q * cfg_i.page_bytes;
    end
  end

  always_comb begin
    bm_cur  = vld_rd_q ? bm_rd_q : '0;
    cnt_cur = vld_rd_q ? cnt_rd_q : '0;
    for (int i = 0; i < NSL; i++) begin
      avail[i] = !bm_cur[i] && (7'(i) < s_eff);
    end
    sl_found = 1'b0;
    sl_enc   = '0;
    for (int i = NSL - 1; i >= 0; i--) begin
      if (avail[i]) begin
        sl_found = 1'b1;
        sl_enc   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    alloc_ok = !noroom_q && sl_found;
    free_hit = page_in_rng && slot_in_rng && bm_cur[slot_in_q[SW-1:0]];
    if (req_q == REQ_ALLOC) begin
      sel_slot = alloc_ok ? sl_enc : '0;
    end else begin
      sel_slot = slot_in_q;
    end
    bit_sel = '0;
    bit_sel[sel_slot[SW-1:0]] = 1'b1;
    if (req_q == REQ_ALLOC) begin
      bm_new   = bm_cur | bit_sel;
      cnt_new  = cnt_cur + 1'b1;
      wr_en    = cmd_i.modify && alloc_ok;
      status_d = alloc_ok ? ST_OK : ST_NOROOM;
    end else begin
      bm_new   = bm_cur & ~bit_sel;
      cnt_new  = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
      wr_en    = cmd_i.modify && free_hit;
      status_d = free_hit ? ST_OK : ST_NOTUSED;
    end
    full_new = (cnt_new >= s_eff);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bm_mem[page_idx]  <= bm_new;
      cnt_mem[page_idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      status_q <= status_d;
      slot_q   <= sel_slot;
      pnf_q    <= (req_q == REQ_ALLOC) && alloc_ok && full_new;
      pne_q    <= (req_q == REQ_FREE) && free_hit && (cnt_new == '0);
      prod_s_q <= sel_slot * cfg_i.slot_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      full_q   <= '0;
      sw_vld_q <= 1'b0;
    end else begin
      sw_vld_q <= cmd_i.sweep_rd;
      if (wr_en) begin
        vld_q[page_idx]  <= 1'b1;
        full_q[page_idx] <= full_new;
      end else if (sw_vld_q) begin
        // count latched by the sweep read; invalid entries read as zero
        full_q[sw_idx_q] <= ((vld_rd_q ? cnt_rd_q : '0) >= s_eff);
      end
    end
  end

  assign addr_sum = 24'(prod_p_q) + 24'(cfg_i.header_bytes) + 24'(prod_s_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o         <= status_q;
      granted_page_o   <= noroom_q ? '0 : page_q;
      granted_slot_o   <= slot_q;
      byte_address_o   <= noroom_q ? '0 : addr_sum[ADDR_W-1:0];
      page_now_full_o  <= pnf_q;
      page_now_empty_o <= pne_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

endmodule

// ===== hdl/two_level_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// two_level_slot_allocator
// Page/slot allocator with a page-full map and per-page slot bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type_i, page_index_i, slot_index_i and raise
//   start; the transaction is taken on a clock edge with start high and busy
//   low. Allocate picks the lowest non-full page and its lowest free slot;
//   free clears the named slot.
//   Result channel: done_o is high for one cycle with status and the grant
//   fields; the receiver cannot stall, so results must be taken as they come.
//   Sequencing: done_o rises on the edge at which busy drops, so the next
//   transaction can be taken on the edge that ends the result cycle; a new
//   transaction is not taken while one is still in its steps. The steps are
//   page search, read of the bitmap and count memories, modify/write back,
//   then address sum.
//   Configuration: APB, register i at byte address 4*i, pready always high.
//   Writing slots per page while idle with start low starts a sweep of the
//   count memory that rebuilds the full map, page by page, with busy high.
//   Reset clears the registers to defaults and marks every page empty;
//   no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module two_level_slot_allocator
  import tlsa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 64,
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               req_type_i,
  input  logic [PAGE_W-1:0]  page_index_i,
  input  logic [SLOT_W-1:0]  slot_index_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [PAGE_W-1:0]  granted_page_o,
  output logic [SLOT_W-1:0]  granted_slot_o,
  output logic [ADDR_W-1:0]  byte_address_o,
  output logic               page_now_full_o,
  output logic               page_now_empty_o
);

  // pages and slots beyond the 6-bit indexes are never reachable
  localparam int unsigned NPG = (NUM_PAGES < 64) ? NUM_PAGES : 64;
  localparam int unsigned NSL = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  cfg_t    cfg;
  logic    sweep_req;
  dp_cmd_t cmd;

  tlsa_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .sweep_req_o (sweep_req)
  );

  tlsa_ctrl #(
    .NPG (NPG)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sweep_req_i (sweep_req),
    .busy_o      (busy),
    .cmd_o       (cmd)
  );

  tlsa_dp #(
    .NPG (NPG),
    .NSL (NSL)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .req_type_i       (req_type_i),
    .page_index_i     (page_index_i),
    .slot_index_i     (slot_index_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_page_o   (granted_page_o),
    .granted_slot_o   (granted_slot_o),
    .byte_address_o   (byte_address_o),
    .page_now_full_o  (page_now_full_o),
    .page_now_empty_o (page_now_empty_o)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_level_slot_allocator. It drives allocate and
// free transactions, keeps a shadow copy of the page maps and counts, and
// compares every grant against the shadow's prediction. Registers are set
// over APB between phases.
// ----------------------------------------------------------------------------
module tb;
  import tlsa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic              full;
    logic              empty;
  } grant_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type_i = REQ_ALLOC;
  logic [PAGE_W-1:0]  page_index_i = '0;
  logic [SLOT_W-1:0]  slot_index_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [PAGE_W-1:0]  granted_page_o;
  logic [SLOT_W-1:0]  granted_slot_o;
  logic [ADDR_W-1:0]  byte_address_o;
  logic               page_now_full_o;
  logic               page_now_empty_o;

  two_level_slot_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .page_index_i    (page_index_i),
    .slot_index_i    (slot_index_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_page_o  (granted_page_o),
    .granted_slot_o  (granted_slot_o),
    .byte_address_o  (byte_address_o),
    .page_now_full_o (page_now_full_o),
    .page_now_empty_o(page_now_empty_o)
  );

  // shadow of the allocator state and registers
  logic [63:0] shadow_bits [64];
  logic [6:0]  shadow_count [64];
  logic        shadow_full [64];
  logic [6:0]  cfg_slots = 7'd64;
  logic [12:0] cfg_slot_bytes = 13'd16;
  logic [16:0] cfg_page_bytes = 17'd8192;
  logic [12:0] cfg_header = 13'd12;
  logic [6:0]  cfg_pages = 7'd64;

  grant_t expected_grants [$];
  int     error_count = 0;
  int     cycle_count = 0;
  bit     gaps_on = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int slot_limit();
    if (cfg_slots < 7'd1) return 1;
    if (cfg_slots > 7'd64) return 64;
    return int'(cfg_slots);
  endfunction

  function automatic int page_limit();
    if (cfg_pages < 7'd1) return 1;
    if (cfg_pages > 7'd64) return 64;
    return int'(cfg_pages);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_address(logic [PAGE_W-1:0] pg,
                                                     logic [SLOT_W-1:0] sl);
    int unsigned sum;
    sum = pg * cfg_page_bytes + cfg_header + sl * cfg_slot_bytes;
    return sum[ADDR_W-1:0];
  endfunction

  function automatic grant_t predict_request(logic req, logic [PAGE_W-1:0] pg,
                                             logic [SLOT_W-1:0] sl);
    grant_t g;
    int     s;
    int     np;
    int     p;
    int     i;
    bit     placed;
    g      = '0;
    s      = slot_limit();
    np     = page_limit();
    placed = 1'b0;
    if (req == REQ_ALLOC) begin
      for (p = 0; p < np && !placed; p++) begin
        if (!shadow_full[p]) begin
          for (i = 0; i < s && !placed; i++) begin
            if (!shadow_bits[p][i]) begin
              shadow_bits[p][i] = 1'b1;
              shadow_count[p]   = shadow_count[p] + 7'd1;
              shadow_full[p]    = (shadow_count[p] >= s);
              g.status = ST_OK;
              g.page   = p[PAGE_W-1:0];
              g.slot   = i[SLOT_W-1:0];
              g.addr   = slot_address(g.page, g.slot);
              g.full   = shadow_full[p];
              placed   = 1'b1;
            end
          end
          // count out of step with bitmap: treat page as full
          if (!placed) shadow_full[p] = 1'b1;
        end
      end
      if (!placed) g.status = ST_NOROOM;
    end else begin
      g.page = pg;
      g.slot = sl;
      g.addr = slot_address(pg, sl);
      if (!shadow_bits[pg][sl]) begin
        g.status = ST_NOTUSED;
      end else begin
        shadow_bits[pg][sl] = 1'b0;
        if (shadow_count[pg] > 7'd0) shadow_count[pg] = shadow_count[pg] - 7'd1;
        shadow_full[pg] = (shadow_count[pg] >= s);
        g.status = ST_OK;
        g.empty  = (shadow_count[pg] == 7'd0);
      end
    end
    return g;
  endfunction

  // random slot currently held, for well-formed frees
  function automatic bit pick_used(output logic [PAGE_W-1:0] pg,
                                   output logic [SLOT_W-1:0] sl);
    int p0;
    int s0;
    int k;
    int j;
    int p;
    int s;
    p0 = $urandom_range(0, 63);
    s0 = $urandom_range(0, 63);
    pg = '0;
    sl = '0;
    for (k = 0; k < 64; k++) begin
      p = (p0 + k) % 64;
      if (shadow_bits[p] != '0) begin
        for (j = 0; j < 64; j++) begin
          s = (s0 + j) % 64;
          if (shadow_bits[p][s]) begin
            pg = p[PAGE_W-1:0];
            sl = s[SLOT_W-1:0];
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // result checker: done_o cannot be held off, so every strobe is a transaction
  always @(posedge clk_i) begin : check_grants
    grant_t want;
    grant_t got;
    if (rst_ni && done_o) begin
      got = '{status_o, granted_page_o, granted_slot_o, byte_address_o,
              page_now_full_o, page_now_empty_o};
      if (expected_grants.size() == 0) begin
        if (error_count < REPORT_MAX)
          $display("ERROR: unexpected result st=%0d pg=%0d sl=%0d", status_o,
                   granted_page_o, granted_slot_o);
        error_count++;
      end else begin
        want = expected_grants.pop_front();
        if (got.status !== want.status || got.page !== want.page ||
            got.slot !== want.slot || got.addr !== want.addr ||
            got.full !== want.full || got.empty !== want.empty) begin
          if (error_count < REPORT_MAX)
            $display({"ERROR: exp st=%0d pg=%0d sl=%0d addr=%0h full=%0b empty=%0b",
                      " / got st=%0d pg=%0d sl=%0d addr=%0h full=%0b empty=%0b"},
                     want.status, want.page, want.slot, want.addr, want.full,
                     want.empty, got.status, got.page, got.slot, got.addr,
                     got.full, got.empty);
          error_count++;
        end
      end
    end
  end

  // called on a rising edge; returns on the edge that takes the transaction,
  // leaving start high so the next request can follow without a gap
  task automatic send_request(input logic req, input logic [PAGE_W-1:0] pg,
                              input logic [SLOT_W-1:0] sl);
    start        <= 1'b1;
    req_type_i   <= req;
    page_index_i <= pg;
    slot_index_i <= sl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_grants.push_back(predict_request(req, pg, sl));
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic await_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_grants.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    int p;
    case (idx)
      REG_SLOTS_PER_PAGE: begin
        cfg_slots = value[6:0];
        for (p = 0; p < 64; p++) shadow_full[p] = (shadow_count[p] >= slot_limit());
      end
      REG_SLOT_BYTES:   cfg_slot_bytes = value[12:0];
      REG_PAGE_BYTES:   cfg_page_bytes = value[16:0];
      REG_HEADER_BYTES: cfg_header = value[12:0];
      REG_PAGES_IN_USE: cfg_pages = value[6:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // a slots-per-page write kicks off the full-map sweep
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_all(input int unsigned slots, input int unsigned sbytes,
                           input int unsigned pbytes, input int unsigned hbytes,
                           input int unsigned pages);
    await_drained();
    write_reg(REG_SLOTS_PER_PAGE, slots);
    write_reg(REG_SLOT_BYTES, sbytes);
    write_reg(REG_PAGE_BYTES, pbytes);
    write_reg(REG_HEADER_BYTES, hbytes);
    write_reg(REG_PAGES_IN_USE, pages);
  endtask

  // mix of allocates, frees of held slots and frees of arbitrary slots
  task automatic run_mix(input int n_items, input int alloc_pct);
    int               n;
    int               r;
    logic [PAGE_W-1:0] pg;
    logic [SLOT_W-1:0] sl;
    for (n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        send_request(REQ_ALLOC, PAGE_W'($urandom_range(0, 63)),
                     SLOT_W'($urandom_range(0, 63)));
      end else if (r < 90 && pick_used(pg, sl)) begin
        send_request(REQ_FREE, pg, sl);
      end else begin
        send_request(REQ_FREE, PAGE_W'($urandom_range(0, 63)),
                     SLOT_W'($urandom_range(0, 63)));
      end
      maybe_gap();
    end
  endtask

  task automatic test_defaults();
    send_request(REQ_ALLOC, 6'd63, 6'd63);
    send_request(REQ_ALLOC, 6'd0, 6'd0);
    send_request(REQ_ALLOC, 6'd21, 6'd42);
    send_request(REQ_FREE, 6'd63, 6'd63);   // never allocated
    send_request(REQ_FREE, 6'd0, 6'd1);
    send_request(REQ_ALLOC, 6'd0, 6'd0);    // takes the freed slot back
    send_request(REQ_FREE, 6'd0, 6'd63);
    send_request(REQ_FREE, 6'd63, 6'd0);
  endtask

  task automatic test_limits_and_clamps();
    // page 0 holds three slots; one slot per page makes it overfull
    write_all(1, 4096, 65536, 4096, 2);
    send_request(REQ_ALLOC, 6'd0, 6'd0);    // page 1 fills
    send_request(REQ_ALLOC, 6'd0, 6'd0);    // nothing left
    send_request(REQ_FREE, 6'd0, 6'd2);     // slot beyond the per-page limit
    send_request(REQ_FREE, 6'd0, 6'd0);
    send_request(REQ_FREE, 6'd0, 6'd1);     // page 0 empties
    send_request(REQ_ALLOC, 6'd0, 6'd0);
    write_all(0, 1, 1, 0, 0);               // zero limits clamp to one
    send_request(REQ_ALLOC, 6'd0, 6'd0);
    send_request(REQ_FREE, 6'd1, 6'd0);     // page beyond pages in use
    send_request(REQ_FREE, 6'd0, 6'd0);
    send_request(REQ_ALLOC, 6'd0, 6'd0);
    write_all(127, 8191, 131071, 8191, 127); // oversize limits clamp to 64
    send_request(REQ_ALLOC, 6'd0, 6'd0);
    send_request(REQ_FREE, 6'd63, 6'd63);   // address wraps
    send_request(REQ_FREE, 6'd0, 6'd1);
    send_request(REQ_FREE, 6'd0, 6'd0);
  endtask

  task automatic test_every_page();
    write_all(1, 16, 8192, 12, 64);
    run_mix(90, 85);
    run_mix(30, 10);
  endtask

  task automatic test_full_page();
    write_all(64, 1, 65536, 0, 1);
    run_mix(90, 85);
    run_mix(30, 15);
  endtask

  task automatic test_random_configs();
    int unsigned slot_opts [8] = '{0, 1, 2, 3, 4, 8, 64, 127};
    int unsigned page_opts [7] = '{0, 1, 2, 3, 4, 64, 127};
    int          ph;
    int unsigned sbytes;
    int unsigned pbytes;
    int unsigned hbytes;
    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: sbytes = 1;
        1: sbytes = 4096;
        2: sbytes = 8191;
        default: sbytes = $urandom_range(0, 8191);
      endcase
      case ($urandom_range(0, 2))
        0: pbytes = 1;
        1: pbytes = 65536;
        default: pbytes = $urandom_range(0, 131071);
      endcase
      case ($urandom_range(0, 2))
        0: hbytes = 0;
        1: hbytes = 4096;
        default: hbytes = $urandom_range(0, 8191);
      endcase
      write_all(slot_opts[$urandom_range(0, 7)], sbytes, pbytes, hbytes,
                page_opts[$urandom_range(0, 6)]);
      gaps_on = (ph != 2);
      run_mix(30, $urandom_range(35, 70));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    write_all(4, 16, 8192, 12, 3);
    gaps_on = 1'b0;
    run_mix(60, 55);
  endtask

  initial begin
    int p;
    for (p = 0; p < 64; p++) begin
      shadow_bits[p]  = '0;
      shadow_count[p] = '0;
      shadow_full[p]  = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_limits_and_clamps();
    test_every_page();
    test_full_page();
    test_random_configs();
    test_back_to_back();

    await_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tlsa_pkg.sv
hdl/tlsa_regs.sv
hdl/tlsa_ctrl.sv
hdl/tlsa_dp.sv
hdl/two_level_slot_allocator.sv
sim/tb.sv
